### hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the bounded double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage : deq_pkg

`default_nettype wire

### hw/rtl/deq_store.sv
// ----------------------------------------------------------------------------
// deq_store
// ring storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module deq_store #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr_a,
  input  wire logic [AW-1:0]         raddr_b,
  output logic      [DATA_WIDTH-1:0] rdata_a,
  output logic      [DATA_WIDTH-1:0] rdata_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data registered, updated only while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule : deq_store

`default_nettype wire

### hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue kept in a ring store
// ----------------------------------------------------------------------------
// usage
//   command channel: drive req and raise start; the transaction is taken at
//   the rising edge where start is high and busy is low. req_type selects
//   push front, push back, pop front, pop back or clear.
//   result channel: every transaction yields one result, shown on result
//   for exactly one cycle while done is high. the receiver cannot stall it.
// timing
//   the accept edge updates the pointers and writes the pushed value; in the
//   READ state the new front and back slots are read from the ring memory,
//   and in the RESP state the result is shown. busy is high in READ and
//   RESP, so a new transaction is not taken until the last has responded.
//   this order is set by the single synchronous memory: a value written at
//   the accept edge is read back through a registered read port.
// reset
//   rst (synchronous) empties the queue and returns the front to slot 0.
//   the memory itself is not cleared; only held slots reach the result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire deq_pkg::req_t req,
  output logic               done,
  output deq_pkg::rsp_t      result
);

  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);       // ring index width
  localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH
  localparam int SW = CW + 1;              // slot sum before wrap
  localparam int VW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [IW-1:0] front;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    rsp_status;
  logic [1:0]    status_next;

  logic                  accept;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;

  logic          is_full;
  logic          is_zero;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail_slot;   // first free slot behind the back
  logic [SW-1:0] back_sum;
  logic [IW-1:0] back_slot;   // slot of the back entry

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign is_full = (count == CW'(DEPTH));
  assign is_zero = (count == '0);

  // ring pointer arithmetic, each a single add and compare
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);

  always_comb begin
    tail_sum = SW'(front) + SW'(count);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_slot = tail_sum[IW-1:0];
  end

  // back slot is only meaningful when the queue is not empty
  always_comb begin
    back_sum = SW'(front) + SW'(count) - SW'(1);
    if (back_sum >= SW'(DEPTH)) begin
      back_sum = back_sum - SW'(DEPTH);
    end
    back_slot = back_sum[IW-1:0];
  end

  // request decode: new pointers, status and the memory write
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    mem_we      = 1'b0;
    mem_waddr   = tail_slot;
    mem_wdata   = DATA_WIDTH'(req.push_value[VW-1:0]);
    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + CW'(1);
          mem_we     = 1'b1;
          mem_waddr  = front_dec;
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          mem_we     = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (is_zero) begin
          status_next = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (is_zero) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      REQ_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
        // unused codes leave the queue as it is
      end
    endcase
  end

  // sequencer: accept, read back, respond
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
    end
  end

  // ring store; reads issued in the READ state, after the write has landed
  deq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (accept && mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (state == S_READ),
    .raddr_a (front),
    .raddr_b (back_slot),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  // result transaction
  assign done               = (state == S_RESP);
  assign result.status      = rsp_status;
  assign result.front_value = is_zero ? '0 : VALUE_W'(rd_front[VW-1:0]);
  assign result.back_value  = is_zero ? '0 : VALUE_W'(rd_back[VW-1:0]);
  assign result.is_empty    = is_zero;
  assign result.entry_count = COUNT_W'(count);

`ifndef SYNTHESIS
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted transaction did not respond two cycles later");

  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_READ)
    else $error("result shown without a preceding read cycle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> count == CW'(DEPTH))
    else $error("full status reported while queue not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> is_zero)
    else $error("empty status reported while queue holds entries");
`endif

endmodule : double_ended_queue

`default_nettype wire
